@@ src/dsm_pkg.sv @@
package dsm_pkg;

    // fixed-point format of x, y and the sine table
    localparam int FRAC_BITS = 24;
    localparam int X_W       = 24;
    localparam int Y_W       = 32;
    localparam int W_W       = 24;
    localparam int K_W       = 28;
    localparam int B_W       = 26;
    localparam int CFG_W     = 28;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_W   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_K    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING_B = 2'd2;

    // register reset values
    localparam logic [W_W-1:0] SHIFT_W_RST   = 24'd0;
    localparam logic [K_W-1:0] KICK_K_RST    = 28'd16273900;
    localparam logic [B_W-1:0] DAMPING_B_RST = 26'd16777216;

    // pi/2 in Q30 and 1/(2pi) in Q32
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
    localparam int          ROM_SHIFT   = 30 - FRAC_BITS;

    // restoring divider: quotient bits and bits retired per stage
    localparam int DIV_Q_W    = 32;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_Q_W / DIV_STEP;

    // item state carried through the divider stages
    typedef struct packed {
        logic               kind;
        logic               neg;
        logic               bzero;
        logic               big;
        logic [B_W-1:0]     rem;
        logic [DIV_Q_W-1:0] lo;
        logic [DIV_Q_W-1:0] quo;
        logic [X_W-1:0]     nx;
        logic [Y_W-1:0]     ny_fwd;
        logic               fwd_flag;
        logic [Y_W-1:0]     jxx;
        logic [Y_W-1:0]     jyx;
        logic               jac_flag;
    } div_t;

    // saturate to 32 bits; msb of the result is the saturation flag
    function automatic logic [Y_W:0] sat32(input logic signed [39:0] v);
        logic [Y_W:0] r;
        if (v > 40'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < -40'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end
        else begin
            r = {1'b0, v[Y_W-1:0]};
        end
        return r;
    endfunction

endpackage

@@ src/dissipative_standard_map_step_core.sv @@
// Dissipative standard map step, forward or inverse, plus Jacobian entries.
// 6 front stages (products, sine table reads and sums), 16 divider stages at 2
// quotient bits each, 1 output reg. Throughput: one item per cycle, stalled only by
// result_ready; every stage has its own valid bit and ready term. Reset (rst_n low,
// async): all valid bits clear, registers return to w=0, k=16273900, b=1.0. The
// sine table is a constant and needs no fill.
module dissipative_standard_map_step_core #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dsm_pkg::CFG_W-1:0]           cfg_data,
    // item input
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                kind,
    input  logic [dsm_pkg::X_W-1:0]             x_coord,
    input  logic signed [dsm_pkg::Y_W-1:0]      y_coord,
    // result output
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [dsm_pkg::X_W-1:0]             next_x,
    output logic signed [dsm_pkg::Y_W-1:0]      next_y,
    output logic signed [dsm_pkg::Y_W-1:0]      jac_xx,
    output logic signed [dsm_pkg::Y_W-1:0]      jac_yx,
    output logic                                flag_sat
);

    localparam int F      = dsm_pkg::FRAC_BITS;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int R_W    = F - 2;
    localparam int PROD_W = R_W + IDX_W;
    localparam int DS     = dsm_pkg::DIV_STAGES;
    // stages S1..S5, S6 (divider setup), then the divider stages
    localparam int NST    = 6 + DS;

    // ------------------------------------------------------------------
    // quarter-wave sine table, Q.F, built at elaboration
    // ------------------------------------------------------------------
    function automatic logic [F:0] sine_entry(input int unsigned i);
        logic [63:0]        th;
        logic [63:0]        th2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] e;
        logic               neg;
        th   = (64'(dsm_pkg::HALF_PI_Q30) * 64'(i) + 64'(SINE_TABLE_DEPTH / 2))
               / 64'(SINE_TABLE_DEPTH);
        th2  = (th * th + (64'd1 << 29)) >> 30;
        term = th;
        sum  = $signed(th);
        neg  = 1'b1;
        for (int n = 1; n < 17; n += 2) begin
            term = ((term * th2 + (64'd1 << 29)) >> 30) / 64'((n + 1) * (n + 2));
            sum  = neg ? sum - $signed(term) : sum + $signed(term);
            neg  = !neg;
        end
        if (sum < 0) begin
            sum = 0;
        end
        e = (sum + (64'sd1 <<< (dsm_pkg::ROM_SHIFT - 1))) >>> dsm_pkg::ROM_SHIFT;
        if (e > (64'sd1 <<< F)) begin
            e = 64'sd1 <<< F;
        end
        return e[F:0];
    endfunction

    logic [F:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    // table address for sin(2pi*a): nearest entry, mirrored in odd quadrants
    function automatic logic [IDX_W-1:0] rom_index(input logic [F-1:0] a);
        logic [PROD_W-1:0] p;
        logic [IDX_W-1:0]  idx;
        p   = PROD_W'(a[R_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH)
              + (PROD_W'(1) << (R_W - 1));
        idx = p[PROD_W-1:R_W];
        if (idx > IDX_W'(SINE_TABLE_DEPTH)) begin
            idx = IDX_W'(SINE_TABLE_DEPTH);
        end
        if (a[F-2]) begin
            idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
        end
        return idx;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [dsm_pkg::W_W-1:0] w_reg;
    logic [dsm_pkg::K_W-1:0] k_reg;
    logic [dsm_pkg::B_W-1:0] b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= dsm_pkg::SHIFT_W_RST;
            k_reg <= dsm_pkg::KICK_K_RST;
            b_reg <= dsm_pkg::DAMPING_B_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dsm_pkg::REG_SHIFT_W:   w_reg <= cfg_data[dsm_pkg::W_W-1:0];
                dsm_pkg::REG_KICK_K:    k_reg <= cfg_data[dsm_pkg::K_W-1:0];
                dsm_pkg::REG_DAMPING_B: b_reg <= cfg_data[dsm_pkg::B_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic           out_valid_reg;

    always_comb
    begin
        rdy[NST] = !out_valid_reg || result_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign item_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0]) begin
                vld_reg[0] <= item_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // S1: b*y and k/(2pi) products, inverse x, sine and cosine arguments
    // ------------------------------------------------------------------
    logic                     s1_kind_reg;
    logic [F-1:0]             s1_x_reg;
    logic signed [31:0]       s1_y_reg;
    logic [F-1:0]             s1_nxi_reg;
    logic [F-1:0]             s1_sa_reg;
    logic [F-1:0]             s1_ca_reg;
    logic signed [58:0]       s1_byp_reg;
    logic [57:0]              s1_kcp_reg;
    logic [F-1:0]             nxi_next;

    assign nxi_next = x_coord - w_reg - y_coord[F-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_kind_reg <= kind;
            s1_x_reg    <= x_coord;
            s1_y_reg    <= y_coord;
            s1_nxi_reg  <= nxi_next;
            // forward kicks at x, inverse kicks at the new x
            s1_sa_reg   <= kind ? nxi_next : x_coord;
            s1_ca_reg   <= x_coord + (F'(1) << (F - 2));
            s1_byp_reg  <= $signed({33'd0, b_reg}) * $signed({{27{y_coord[31]}}, y_coord});
            s1_kcp_reg  <= 58'(k_reg) * 58'(dsm_pkg::INV_2PI_Q32);
        end
    end

    // ------------------------------------------------------------------
    // S2: table indexes, rounding of b*y and kc
    // ------------------------------------------------------------------
    logic               s2_kind_reg;
    logic [F-1:0]       s2_x_reg;
    logic signed [31:0] s2_y_reg;
    logic [F-1:0]       s2_nxi_reg;
    logic [IDX_W-1:0]   s2_sidx_reg;
    logic [IDX_W-1:0]   s2_cidx_reg;
    logic               s2_sneg_reg;
    logic               s2_cneg_reg;
    logic signed [35:0] s2_by_reg;
    logic [25:0]        s2_kc_reg;
    logic signed [58:0] byp_rnd;
    logic [57:0]        kcp_rnd;

    assign byp_rnd = s1_byp_reg + (59'sd1 <<< (F - 1));
    assign kcp_rnd = s1_kcp_reg + (58'd1 << 31);

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_nxi_reg  <= s1_nxi_reg;
            s2_sidx_reg <= rom_index(s1_sa_reg);
            s2_cidx_reg <= rom_index(s1_ca_reg);
            s2_sneg_reg <= s1_sa_reg[F-1];
            s2_cneg_reg <= s1_ca_reg[F-1];
            s2_by_reg   <= 36'(byp_rnd >>> F);
            s2_kc_reg   <= 26'(kcp_rnd >> 32);
        end
    end

    // ------------------------------------------------------------------
    // S3: table reads (two ports, registered)
    // ------------------------------------------------------------------
    logic               s3_kind_reg;
    logic [F-1:0]       s3_x_reg;
    logic signed [31:0] s3_y_reg;
    logic [F-1:0]       s3_nxi_reg;
    logic [F:0]         s3_sraw_reg;
    logic [F:0]         s3_craw_reg;
    logic               s3_sneg_reg;
    logic               s3_cneg_reg;
    logic signed [35:0] s3_by_reg;
    logic [25:0]        s3_kc_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_x_reg    <= s2_x_reg;
            s3_y_reg    <= s2_y_reg;
            s3_nxi_reg  <= s2_nxi_reg;
            s3_sraw_reg <= sine_rom[s2_sidx_reg];
            s3_craw_reg <= sine_rom[s2_cidx_reg];
            s3_sneg_reg <= s2_sneg_reg;
            s3_cneg_reg <= s2_cneg_reg;
            s3_by_reg   <= s2_by_reg;
            s3_kc_reg   <= s2_kc_reg;
        end
    end

    // ------------------------------------------------------------------
    // S4: kc*sin and k*cos products
    // ------------------------------------------------------------------
    logic               s4_kind_reg;
    logic [F-1:0]       s4_x_reg;
    logic signed [31:0] s4_y_reg;
    logic [F-1:0]       s4_nxi_reg;
    logic signed [35:0] s4_by_reg;
    logic signed [52:0] s4_kickp_reg;
    logic signed [54:0] s4_tp_reg;
    logic signed [F+1:0] sin_val;
    logic signed [F+1:0] cos_val;

    assign sin_val = s3_sneg_reg ? -$signed({1'b0, s3_sraw_reg}) : $signed({1'b0, s3_sraw_reg});
    assign cos_val = s3_cneg_reg ? -$signed({1'b0, s3_craw_reg}) : $signed({1'b0, s3_craw_reg});

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s4_kind_reg  <= s3_kind_reg;
            s4_x_reg     <= s3_x_reg;
            s4_y_reg     <= s3_y_reg;
            s4_nxi_reg   <= s3_nxi_reg;
            s4_by_reg    <= s3_by_reg;
            s4_kickp_reg <= $signed({27'd0, s3_kc_reg}) * 53'(sin_val);
            s4_tp_reg    <= $signed({27'd0, k_reg}) * 55'(cos_val);
        end
    end

    // ------------------------------------------------------------------
    // S5: round the kick and k*cos, form forward y and inverse numerator
    // ------------------------------------------------------------------
    logic               s5_kind_reg;
    logic [F-1:0]       s5_x_reg;
    logic [F-1:0]       s5_nxi_reg;
    logic signed [33:0] s5_num_reg;
    logic signed [36:0] s5_diff_reg;
    logic signed [29:0] s5_t_reg;
    logic signed [52:0] kickp_rnd;
    logic signed [54:0] tp_rnd;
    logic signed [27:0] kick;

    assign kickp_rnd = s4_kickp_reg + (53'sd1 <<< (F - 1));
    assign tp_rnd    = s4_tp_reg + (55'sd1 <<< (F - 1));
    assign kick      = 28'(kickp_rnd >>> F);

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            s5_kind_reg <= s4_kind_reg;
            s5_x_reg    <= s4_x_reg;
            s5_nxi_reg  <= s4_nxi_reg;
            s5_num_reg  <= 34'(s4_y_reg) + 34'(kick);
            s5_diff_reg <= 37'(s4_by_reg) - 37'(kick);
            s5_t_reg    <= 30'(tp_rnd >>> F);
        end
    end

    // ------------------------------------------------------------------
    // S6: saturation of forward y and Jacobian, divider setup
    // ------------------------------------------------------------------
    dsm_pkg::div_t div_reg [DS+1];
    dsm_pkg::div_t div_init;
    logic [32:0]   fwd_sat;
    logic [32:0]   jxx_sat;
    logic [32:0]   jyx_sat;
    logic [33:0]   num_abs;
    logic [57:0]   dividend;

    always_comb
    begin
        fwd_sat  = dsm_pkg::sat32(40'(s5_diff_reg));
        jxx_sat  = dsm_pkg::sat32((40'sd1 <<< F) - 40'(s5_t_reg));
        jyx_sat  = dsm_pkg::sat32(-40'(s5_t_reg));
        num_abs  = s5_num_reg[33] ? 34'(-s5_num_reg) : 34'(s5_num_reg);
        // |num| * 2^F + b/2, quotient rounds half away from zero after sign fix
        dividend = 58'({num_abs[32:0], F'(0)}) + 58'(b_reg[dsm_pkg::B_W-1:1]);

        div_init.kind     = s5_kind_reg;
        div_init.neg      = s5_num_reg[33];
        div_init.bzero    = (b_reg == '0);
        div_init.big      = (dividend[57:32] >= b_reg);
        div_init.rem      = dividend[57:32];
        div_init.lo       = dividend[31:0];
        div_init.quo      = '0;
        div_init.nx       = s5_kind_reg ? s5_nxi_reg
                                        : s5_x_reg + w_reg + fwd_sat[F-1:0];
        div_init.ny_fwd   = fwd_sat[31:0];
        div_init.fwd_flag = fwd_sat[32];
        div_init.jxx      = jxx_sat[31:0];
        div_init.jyx      = jyx_sat[31:0];
        div_init.jac_flag = jxx_sat[32] | jyx_sat[32];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            div_reg[0] <= div_init;
        end
    end

    // ------------------------------------------------------------------
    // divider: restoring, DIV_STEP quotient bits per stage, msb first.
    // Only the low 32 quotient bits are formed; big marks a larger quotient.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < DS; j++) begin : g_div
        dsm_pkg::div_t d_next;
        logic [dsm_pkg::B_W:0] trial;

        always_comb
        begin
            d_next = div_reg[j];
            trial  = '0;
            for (int s = 0; s < dsm_pkg::DIV_STEP; s++) begin
                trial     = {d_next.rem, d_next.lo[dsm_pkg::DIV_Q_W-1]};
                d_next.lo = d_next.lo << 1;
                if (trial >= {1'b0, b_reg}) begin
                    trial      = trial - {1'b0, b_reg};
                    d_next.quo = {d_next.quo[dsm_pkg::DIV_Q_W-2:0], 1'b1};
                end
                else begin
                    d_next.quo = {d_next.quo[dsm_pkg::DIV_Q_W-2:0], 1'b0};
                end
                d_next.rem = trial[dsm_pkg::B_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[6+j])
            begin
                div_reg[j+1] <= d_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: sign and saturate the quotient, pick by kind
    // ------------------------------------------------------------------
    dsm_pkg::div_t     d_last;
    logic [31:0]       ny_sel;
    logic              flag_sel;
    logic [F-1:0]      nx_out_reg;
    logic [31:0]       ny_out_reg;
    logic [31:0]       jxx_out_reg;
    logic [31:0]       jyx_out_reg;
    logic              flag_out_reg;

    assign d_last = div_reg[DS];

    always_comb
    begin
        ny_sel   = d_last.ny_fwd;
        flag_sel = d_last.fwd_flag;
        priority if (!d_last.kind) begin
            ny_sel   = d_last.ny_fwd;
            flag_sel = d_last.fwd_flag;
        end
        else if (d_last.bzero) begin
            ny_sel   = '0;
            flag_sel = 1'b1;
        end
        else if (!d_last.neg) begin
            if (d_last.big || d_last.quo[31]) begin
                ny_sel   = 32'h7FFF_FFFF;
                flag_sel = 1'b1;
            end
            else begin
                ny_sel   = d_last.quo;
                flag_sel = 1'b0;
            end
        end
        else begin
            if (d_last.big || (d_last.quo > 32'h8000_0000)) begin
                ny_sel   = 32'h8000_0000;
                flag_sel = 1'b1;
            end
            else begin
                ny_sel   = -d_last.quo;
                flag_sel = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy[NST])
        begin
            out_valid_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NST])
        begin
            nx_out_reg   <= d_last.nx;
            ny_out_reg   <= ny_sel;
            jxx_out_reg  <= d_last.jxx;
            jyx_out_reg  <= d_last.jyx;
            flag_out_reg <= flag_sel | d_last.jac_flag;
        end
    end

    assign result_valid = out_valid_reg;
    assign next_x       = nx_out_reg;
    assign next_y       = ny_out_reg;
    assign jac_xx       = jxx_out_reg;
    assign jac_yx       = jyx_out_reg;
    assign flag_sat     = flag_out_reg;

`ifndef SYNTHESIS
    // input side only blocks when every stage is full and the result is held
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input stalled with room in the pipeline");

    // inverse with b equal to zero gives zero and raises the flag
    a_bzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NST-1] && d_last.kind && d_last.bzero && rdy[NST]
        |=> flag_sat && next_y == '0)
        else $error("inverse with zero damping not flagged");

    // unsaturated Jacobian entries differ by exactly one
    a_jac: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !flag_sat |-> (jac_xx - jac_yx) == (32'sd1 <<< F))
        else $error("Jacobian entries inconsistent");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int ROM_DEPTH = 1024;
    localparam int STALL_LIMIT = 4000;

    typedef enum logic {KIND_FWD = 1'b0, KIND_INV = 1'b1} map_kind_e;

    typedef struct packed {
        logic                    kind;
        logic [dsm_pkg::X_W-1:0] x;
        logic [dsm_pkg::Y_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic [dsm_pkg::X_W-1:0] nx;
        logic [dsm_pkg::Y_W-1:0] ny;
        logic [dsm_pkg::Y_W-1:0] jxx;
        logic [dsm_pkg::Y_W-1:0] jyx;
        logic                    flag;
    } step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [dsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dsm_pkg::CFG_W-1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic kind = 1'b0;
    logic [dsm_pkg::X_W-1:0] x_coord = '0;
    logic signed [dsm_pkg::Y_W-1:0] y_coord = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [dsm_pkg::X_W-1:0] next_x;
    logic signed [dsm_pkg::Y_W-1:0] next_y, jac_xx, jac_yx;
    logic flag_sat;

    // mirror of the configuration
    logic [dsm_pkg::W_W-1:0] map_w = dsm_pkg::SHIFT_W_RST;
    logic [dsm_pkg::K_W-1:0] map_k = dsm_pkg::KICK_K_RST;
    logic [dsm_pkg::B_W-1:0] map_b = dsm_pkg::DAMPING_B_RST;

    longint sine_tab [0:ROM_DEPTH];
    point_t pending_points[$];
    step_t  expected_steps[$];

    int send_idle_pct = 23;
    int recv_idle_pct = 84;
    bit hold_recv = 1'b0;
    bit stim_done = 1'b0;
    bit in_fire = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    dissipative_standard_map_step_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .item_valid(item_valid), .item_ready(item_ready),
        .kind(kind), .x_coord(x_coord), .y_coord(y_coord),
        .result_valid(result_valid), .result_ready(result_ready),
        .next_x(next_x), .next_y(next_y), .jac_xx(jac_xx), .jac_yx(jac_yx),
        .flag_sat(flag_sat)
    );

    // quarter-wave sine table, Taylor series in Q30 rounded to Q24
    function automatic void build_sine_tab();
        longint unsigned th, th2, term;
        longint s;
        bit neg;
        for (int i = 0; i <= ROM_DEPTH; i++)
        begin
            th = (64'(dsm_pkg::HALF_PI_Q30) * i + ROM_DEPTH / 2) / ROM_DEPTH;
            th2 = (th * th + (64'd1 << 29)) >> 30;
            term = th;
            s = th;
            neg = 1'b1;
            for (int n = 1; n < 17; n += 2)
            begin
                term = ((term * th2 + (64'd1 << 29)) >> 30) / ((n + 1) * (n + 2));
                s = neg ? s - longint'(term) : s + longint'(term);
                neg = !neg;
            end
            if (s < 0) s = 0;
            s = (s + (64'sd1 << (dsm_pkg::ROM_SHIFT - 1))) >>> dsm_pkg::ROM_SHIFT;
            if (s > (64'sd1 << dsm_pkg::FRAC_BITS)) s = 64'sd1 << dsm_pkg::FRAC_BITS;
            sine_tab[i] = s;
        end
    endfunction

    // arithmetic shift with floor is exact for signed longint
    function automatic longint rnd_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp32(longint v, ref bit f);
        if (v > 64'sd2147483647) begin f = 1'b1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin f = 1'b1; return -64'sd2147483648; end
        return v;
    endfunction

    function automatic longint sine_2pi(logic [dsm_pkg::X_W-1:0] x);
        logic [1:0] q;
        longint unsigned r, idx;
        longint v;
        q = x[dsm_pkg::X_W-1 -: 2];
        r = x[dsm_pkg::X_W-3:0];
        idx = (r * ROM_DEPTH + (64'd1 << (dsm_pkg::FRAC_BITS - 3))) >> (dsm_pkg::FRAC_BITS - 2);
        if (idx > ROM_DEPTH) idx = ROM_DEPTH;
        v = q[0] ? sine_tab[ROM_DEPTH - idx] : sine_tab[idx];
        return q[1] ? -v : v;
    endfunction

    function automatic longint kick_of(logic [dsm_pkg::X_W-1:0] x);
        longint kc;
        kc = longint'((64'(map_k) * 64'(dsm_pkg::INV_2PI_Q32) + (64'd1 << 31)) >> 32);
        return rnd_shift(kc * sine_2pi(x), dsm_pkg::FRAC_BITS);
    endfunction

    function automatic step_t map_step(point_t p);
        step_t o;
        bit f;
        longint y, ny, num, q, c, t;
        longint unsigned mag, qm;
        logic [dsm_pkg::X_W-1:0] nx;
        f = 1'b0;
        y = longint'(signed'(p.y));
        if (p.kind == KIND_FWD)
        begin
            ny = clamp32(rnd_shift(longint'(map_b) * y, dsm_pkg::FRAC_BITS) - kick_of(p.x), f);
            nx = p.x + map_w + dsm_pkg::X_W'(ny);
        end
        else
        begin
            nx = p.x - map_w - dsm_pkg::X_W'(y);
            if (map_b == 0)
            begin
                f = 1'b1;
                ny = 0;
            end
            else
            begin
                num = y + kick_of(nx);
                mag = longint'(num < 0 ? -num : num) << dsm_pkg::FRAC_BITS;
                qm = (mag + map_b / 2) / map_b;
                q = (qm > 64'h3FFF_FFFF_FFFF_FFFF) ? 64'sh3FFF_FFFF_FFFF_FFFF : longint'(qm);
                ny = clamp32(num < 0 ? -q : q, f);
            end
        end
        c = sine_2pi(p.x + (dsm_pkg::X_W'(1) << (dsm_pkg::FRAC_BITS - 2)));
        t = rnd_shift(longint'(map_k) * c, dsm_pkg::FRAC_BITS);
        o.jxx = dsm_pkg::Y_W'(clamp32((64'sd1 << dsm_pkg::FRAC_BITS) - t, f));
        o.jyx = dsm_pkg::Y_W'(clamp32(-t, f));
        o.nx = nx;
        o.ny = dsm_pkg::Y_W'(ny);
        o.flag = f;
        return o;
    endfunction

    // driver: offers the head of the pending queue, idles at random;
    // a new item is only offered once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || in_fire)
            begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_valid <= 1'b1;
                    kind <= pending_points[0].kind;
                    x_coord <= pending_points[0].x;
                    y_coord <= pending_points[0].y;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
            result_ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // prediction at acceptance; pop the driven point
    always @(posedge clk)
    begin
        in_fire <= rst_n && item_valid && item_ready;
        if (rst_n && item_valid && item_ready)
        begin
            expected_steps.push_back(map_step(pending_points.pop_front()));
        end
    end

    // monitor
    always @(posedge clk)
    begin
        step_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_steps.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_steps.pop_front();
                if (next_x !== e.nx)
                begin
                    $error("next_x: expected %h, got %h", e.nx, next_x);
                    errors++;
                end
                if (next_y !== e.ny)
                begin
                    $error("next_y: expected %h, got %h", e.ny, next_y);
                    errors++;
                end
                if (jac_xx !== e.jxx)
                begin
                    $error("jac_xx: expected %h, got %h", e.jxx, jac_xx);
                    errors++;
                end
                if (jac_yx !== e.jyx)
                begin
                    $error("jac_yx: expected %h, got %h", e.jyx, jac_yx);
                    errors++;
                end
                if (flag_sat !== e.flag)
                begin
                    $error("flag_sat: expected %b, got %b", e.flag, flag_sat);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT && !stim_done)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // long receiver hold-off, counted here, while the sender keeps offering
    task automatic hold_off_receiver(int cycles);
        hold_recv = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_recv = 1'b0;
    endtask

    task automatic add_point(logic k, logic [dsm_pkg::X_W-1:0] x, logic [dsm_pkg::Y_W-1:0] y);
        point_t p;
        p.kind = k;
        p.x = x;
        p.y = y;
        pending_points.push_back(p);
    endtask

    task automatic add_random(int n);
        logic [dsm_pkg::Y_W-1:0] y;
        for (int i = 0; i < n; i++)
        begin
            // mostly small momenta, some full range
            case ($urandom_range(3))
                0: y = $urandom();
                1: y = dsm_pkg::Y_W'(signed'($urandom_range(1 << 26) - (1 << 25)));
                default: y = dsm_pkg::Y_W'(signed'($urandom_range(1 << 25) - (1 << 24)));
            endcase
            add_point(1'($urandom_range(1)), dsm_pkg::X_W'($urandom()), y);
        end
    endtask

    // wait until every queued point is accepted and answered, then drain
    task automatic drain();
        while (pending_points.size() > 0 || expected_steps.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [dsm_pkg::CFG_IDX_W-1:0] idx,
                             logic [dsm_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            dsm_pkg::REG_SHIFT_W: map_w = val[dsm_pkg::W_W-1:0];
            dsm_pkg::REG_KICK_K: map_k = val[dsm_pkg::K_W-1:0];
            dsm_pkg::REG_DAMPING_B: map_b = val[dsm_pkg::B_W-1:0];
            default: ;
        endcase
    endtask

    initial
    begin
        build_sine_tab();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, both kinds, quadrant boundaries
        add_point(KIND_FWD, '0, '0);
        add_point(KIND_INV, '0, '0);
        add_point(KIND_FWD, 24'hFFFFFF, 32'h7FFFFFFF);
        add_point(KIND_INV, 24'hFFFFFF, 32'h80000000);
        add_point(KIND_FWD, 24'h400000, 32'h80000000);
        add_point(KIND_INV, 24'h800000, 32'h7FFFFFFF);
        add_point(KIND_FWD, 24'hC00000, 32'h01000000);
        add_point(KIND_INV, 24'h200000, 32'hFF000000);
        add_point(KIND_FWD, 24'h555555, 32'hAAAAAAAA);
        add_point(KIND_INV, 24'hAAAAAA, 32'h55555555);
        add_random(100);
        hold_off_receiver(300);
        drain();

        // max k and w, b = 0 for the inverse special case
        write_reg(dsm_pkg::REG_SHIFT_W, 28'hFFFFFF);
        write_reg(dsm_pkg::REG_KICK_K, 28'hFFFFFFF);
        write_reg(dsm_pkg::REG_DAMPING_B, 28'd0);
        add_point(KIND_INV, 24'h123456, 32'h01234567);
        add_point(KIND_FWD, 24'h000000, 32'h7FFFFFFF);
        add_random(120);
        drain();

        send_idle_pct = 84;
        recv_idle_pct = 23;
        write_reg(dsm_pkg::REG_DAMPING_B, 28'd33554432);
        write_reg(dsm_pkg::REG_KICK_K, 28'd0);
        write_reg(dsm_pkg::REG_SHIFT_W, 28'd0);
        add_random(120);
        drain();

        write_reg(dsm_pkg::REG_DAMPING_B, 28'd1);
        write_reg(dsm_pkg::REG_KICK_K, dsm_pkg::CFG_W'($urandom_range(28'hFFFFFFF)));
        write_reg(dsm_pkg::REG_SHIFT_W, dsm_pkg::CFG_W'($urandom_range(24'hFFFFFF)));
        add_random(100);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(dsm_pkg::REG_DAMPING_B, 28'd12000000);
        write_reg(dsm_pkg::REG_KICK_K, 28'd16273900);
        add_random(200);
        drain();

        stim_done = 1'b1;
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/dsm_pkg.sv
src/dissipative_standard_map_step_core.sv
tb/testbench.sv
